>>> src/ring_node_table_aging_core_defines.svh
// Assertion macros for the ring node table aging core.
`ifndef RING_NODE_TABLE_AGING_CORE_DEFINES_SVH
`define RING_NODE_TABLE_AGING_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RNTA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnta same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RNTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnta next-cycle check failed");

`endif

>>> src/rnta_pkg.sv
// Shared types and constants for the ring node table aging core.
package rnta_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int MAC_W         = 48;
   localparam int SEQ_W         = 8;
   localparam int TLV_W         = 24;
   localparam int CFG_W         = 8;

   localparam logic [CFG_W-1:0] LIFETIME_RESET = 8'd60;
   localparam logic [CFG_W-1:0] AGE_STEP_RESET = 8'd2;

   typedef enum logic {
      CSR_ENTRY_LIFETIME = 1'b0,
      CSR_AGE_STEP       = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic {
      PATH_LEFT  = 1'b0,
      PATH_RIGHT = 1'b1
   } path_type;

   typedef enum logic [1:0] {
      STATUS_REFRESHED = 2'd0,
      STATUS_INSERTED  = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_TICK_DONE = 2'd3
   } status_type;

   typedef struct packed {
      logic [MAC_W-1:0] key;
      logic [MAC_W-1:0] redbox;
      logic [TLV_W-1:0] tlv;
      logic [SEQ_W-1:0] seq_left;
      logic [SEQ_W-1:0] seq_right;
      logic [CFG_W-1:0] lifetime;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic start;
      logic scan;
      logic write;
      logic mark_full;
      logic commit_tick;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_tick;
      logic match;
      logic scan_done;
      logic table_full;
   } dp_status_type;

endpackage

>>> src/rnta_ram.sv
// Generic simple dual-port RAM with registered read.
module rnta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rnta_ctrl.sv
// Controller state machine for the ring node table aging core.
module rnta_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rnta_pkg::ctrl_cmd_type  ctrl_cmd,
   input  rnta_pkg::dp_status_type dp_status
);
   import rnta_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WRITE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl_cmd.scan = 1'b1;
            priority if (dp_status.op_tick) begin
               if (dp_status.scan_done) begin
                  ctrl_cmd.commit_tick = 1'b1;
                  state_in             = ST_FINISH;
               end
            end else if (dp_status.match) begin
               state_in = ST_WRITE;
            end else if (dp_status.scan_done) begin
               if (dp_status.table_full) begin
                  ctrl_cmd.mark_full = 1'b1;
                  state_in           = ST_FINISH;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            ctrl_cmd.write = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl_cmd.load_rsp = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = ctrl_cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/rnta_dpath.sv
// Datapath of the ring node table aging core: table RAM, counters, config, result.
module rnta_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  rnta_pkg::ctrl_cmd_type      ctrl_cmd,
   output rnta_pkg::dp_status_type     dp_status,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [rnta_pkg::CFG_W-1:0]  csr_data,
   input  logic                        req_op,
   input  logic [rnta_pkg::MAC_W-1:0]  req_node_mac,
   input  logic [rnta_pkg::MAC_W-1:0]  req_sender_mac,
   input  logic [rnta_pkg::SEQ_W-1:0]  req_seq_num,
   input  logic [7:0]                  req_tlv_zero_type,
   input  logic [7:0]                  req_tlv_one_type,
   input  logic [7:0]                  req_tlv_two_type,
   input  logic                        req_ring_path,
   output logic [1:0]                  rsp_status,
   output logic [4:0]                  rsp_entry_index,
   output logic [5:0]                  rsp_node_count,
   output logic [5:0]                  rsp_removed_count
);
   import rnta_pkg::*;

   logic [CFG_W-1:0] lifetime_cfg_ff, lifetime_cfg_in;
   logic [CFG_W-1:0] step_cfg_ff, step_cfg_in;
   logic [CNT_W-1:0] vc_ff, vc_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic             hit_ff, hit_in;

   op_type           op_ff, op_in;
   path_type         path_ff, path_in;
   logic [MAC_W-1:0] key_ff, key_in;
   logic [MAC_W-1:0] redbox_ff, redbox_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [TLV_W-1:0] tlv_ff, tlv_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SEQ_W-1:0] old_left_ff, old_left_in;
   logic [SEQ_W-1:0] old_right_ff, old_right_in;
   status_type       res_status_ff, res_status_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [4:0]       rsp_index_ff, rsp_index_in;
   logic [5:0]       rsp_count_ff, rsp_count_in;
   logic [5:0]       rsp_removed_ff, rsp_removed_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_entry;
   logic             issue_more;
   logic             keep;

   rnta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry   = entry_type'(ram_rdata);
   assign issue_more = (issue_ff < vc_ff);
   assign keep       = (rd_entry.lifetime > step_cfg_ff);
   assign ram_raddr  = issue_ff[IDX_W-1:0];

   assign dp_status.op_tick    = (op_ff == OP_TICK);
   assign dp_status.match      = pend_ff && (op_ff == OP_UPDATE) && (rd_entry.key == key_ff);
   assign dp_status.scan_done  = !issue_more && !pend_ff;
   assign dp_status.table_full = (vc_ff >= CNT_W'(TABLE_ENTRIES));

   always_comb begin
      lifetime_cfg_in = lifetime_cfg_ff;
      step_cfg_in     = step_cfg_ff;
      vc_in           = vc_ff;
      issue_in        = issue_ff;
      pend_in         = pend_ff;
      hit_in          = hit_ff;
      op_in           = op_ff;
      path_in         = path_ff;
      key_in          = key_ff;
      redbox_in       = redbox_ff;
      seq_in          = seq_ff;
      tlv_in          = tlv_ff;
      pend_idx_in     = pend_idx_ff;
      pos_in          = pos_ff;
      wr_in           = wr_ff;
      rem_in          = rem_ff;
      old_left_in     = old_left_ff;
      old_right_in    = old_right_ff;
      res_status_in   = res_status_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_removed_in  = rsp_removed_ff;
      ram_we          = 1'b0;
      ram_waddr       = wr_ff[IDX_W-1:0];
      ram_wdata       = rd_entry;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENTRY_LIFETIME: lifetime_cfg_in = csr_data;
            CSR_AGE_STEP:       step_cfg_in     = csr_data;
            default:            lifetime_cfg_in = lifetime_cfg_ff;
         endcase
      end

      if (ctrl_cmd.start) begin
         op_in     = op_type'(req_op);
         path_in   = path_type'(req_ring_path);
         key_in    = req_node_mac;
         redbox_in = req_sender_mac;
         seq_in    = req_seq_num;
         tlv_in    = {req_tlv_zero_type, req_tlv_one_type, req_tlv_two_type};
         issue_in  = '0;
         pend_in   = 1'b0;
         hit_in    = 1'b0;
         wr_in     = '0;
         rem_in    = '0;
      end

      if (ctrl_cmd.scan) begin
         pend_in     = issue_more;
         pend_idx_in = issue_ff[IDX_W-1:0];
         if (issue_more) begin
            issue_in = issue_ff + 1'b1;
         end
         if (dp_status.match) begin
            hit_in       = 1'b1;
            pos_in       = pend_idx_ff;
            old_left_in  = rd_entry.seq_left;
            old_right_in = rd_entry.seq_right;
         end
         if (dp_status.op_tick && pend_ff) begin
            if (keep) begin
               ram_we             = 1'b1;
               ram_waddr          = wr_ff[IDX_W-1:0];
               ram_wdata          = rd_entry;
               ram_wdata.lifetime = rd_entry.lifetime - step_cfg_ff;
               wr_in              = wr_ff + 1'b1;
            end else begin
               rem_in = rem_ff + 1'b1;
            end
         end
      end

      if (ctrl_cmd.write) begin
         ram_we             = 1'b1;
         ram_wdata.key      = key_ff;
         ram_wdata.redbox   = redbox_ff;
         ram_wdata.tlv      = tlv_ff;
         ram_wdata.lifetime = lifetime_cfg_ff;
         ram_wdata.seq_left  = (path_ff == PATH_LEFT) ? seq_ff :
                               (hit_ff ? old_left_ff : '0);
         ram_wdata.seq_right = (path_ff == PATH_RIGHT) ? seq_ff :
                               (hit_ff ? old_right_ff : '0);
         if (hit_ff) begin
            ram_waddr     = pos_ff;
            res_status_in = STATUS_REFRESHED;
         end else begin
            ram_waddr     = vc_ff[IDX_W-1:0];
            pos_in        = vc_ff[IDX_W-1:0];
            vc_in         = vc_ff + 1'b1;
            res_status_in = STATUS_INSERTED;
         end
      end

      if (ctrl_cmd.mark_full) begin
         res_status_in = STATUS_FULL;
         pos_in        = '0;
      end

      if (ctrl_cmd.commit_tick) begin
         vc_in         = wr_ff;
         res_status_in = STATUS_TICK_DONE;
         pos_in        = '0;
      end

      if (ctrl_cmd.load_rsp) begin
         rsp_status_in  = res_status_ff;
         rsp_index_in   = 5'(pos_ff);
         rsp_count_in   = 6'(vc_ff);
         rsp_removed_in = (op_ff == OP_TICK) ? 6'(rem_ff) : 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_cfg_ff <= LIFETIME_RESET;
         step_cfg_ff     <= AGE_STEP_RESET;
         vc_ff           <= '0;
         issue_ff        <= '0;
         pend_ff         <= 1'b0;
         hit_ff          <= 1'b0;
      end else begin
         lifetime_cfg_ff <= lifetime_cfg_in;
         step_cfg_ff     <= step_cfg_in;
         vc_ff           <= vc_in;
         issue_ff        <= issue_in;
         pend_ff         <= pend_in;
         hit_ff          <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      path_ff        <= path_in;
      key_ff         <= key_in;
      redbox_ff      <= redbox_in;
      seq_ff         <= seq_in;
      tlv_ff         <= tlv_in;
      pend_idx_ff    <= pend_idx_in;
      pos_ff         <= pos_in;
      wr_ff          <= wr_in;
      rem_ff         <= rem_in;
      old_left_ff    <= old_left_in;
      old_right_ff   <= old_right_in;
      res_status_ff  <= res_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_node_count    = rsp_count_ff;
   assign rsp_removed_count = rsp_removed_ff;

endmodule

>>> src/ring_node_table_aging_core.sv
// Top level of the ring node table aging core.
// One beat at a time; the table RAM is walked one entry a cycle through its single read port.
// Tick: the valid entries are read in order; survivors are written back packed at the front with
// lifetime less the age step. Update: a hit refreshes its slot, a miss appends, a full table refuses.
// The next beat is taken only once the result is loaded, which waits while a held result is stalled.
// Reset: node count to zero, lifetime 60, age step 2; table contents are not cleared.
`include "ring_node_table_aging_core_defines.svh"

module ring_node_table_aging_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [rnta_pkg::CFG_W-1:0] csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [rnta_pkg::MAC_W-1:0] req_node_mac,
   input  logic [rnta_pkg::MAC_W-1:0] req_sender_mac,
   input  logic [rnta_pkg::SEQ_W-1:0] req_seq_num,
   input  logic [7:0]                 req_tlv_zero_type,
   input  logic [7:0]                 req_tlv_one_type,
   input  logic [7:0]                 req_tlv_two_type,
   input  logic                       req_ring_path,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [4:0]                 rsp_entry_index,
   output logic [5:0]                 rsp_node_count,
   output logic [5:0]                 rsp_removed_count
);
   import rnta_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   rnta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

   rnta_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_op            (req_op),
      .req_node_mac      (req_node_mac),
      .req_sender_mac    (req_sender_mac),
      .req_seq_num       (req_seq_num),
      .req_tlv_zero_type (req_tlv_zero_type),
      .req_tlv_one_type  (req_tlv_one_type),
      .req_tlv_two_type  (req_tlv_two_type),
      .req_ring_path     (req_ring_path),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_node_count    (rsp_node_count),
      .rsp_removed_count (rsp_removed_count)
   );

   `RNTA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RNTA_ASSERT_NEXT(a_rsp_after_load, clock, reset, ctrl_cmd.load_rsp, rsp_valid)
   `RNTA_ASSERT_NOW(a_commit_at_end, clock, reset, ctrl_cmd.commit_tick, dp_status.scan_done)
   `RNTA_ASSERT_NOW(a_full_only_when_full, clock, reset, ctrl_cmd.mark_full, dp_status.table_full)

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ring node table aging core.
module tb;
   import rnta_pkg::*;

   localparam int RANDOM_BEATS = 1800;
   localparam int DRAIN_LIMIT  = 5000;

   typedef struct {
      op_type           op;
      logic [MAC_W-1:0] node_mac;
      logic [MAC_W-1:0] sender_mac;
      logic [SEQ_W-1:0] seq_num;
      logic [7:0]       tlv_zero;
      logic [7:0]       tlv_one;
      logic [7:0]       tlv_two;
      path_type         path;
   } frame_type;

   typedef struct {
      status_type status;
      logic [4:0] index;
      logic [5:0] count;
      logic [5:0] removed;
   } report_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   csr_index_type    csr_index;
   logic [CFG_W-1:0] csr_data;
   logic             req_valid;
   logic             req_stall;
   logic             req_op;
   logic [MAC_W-1:0] req_node_mac;
   logic [MAC_W-1:0] req_sender_mac;
   logic [SEQ_W-1:0] req_seq_num;
   logic [7:0]       req_tlv_zero_type;
   logic [7:0]       req_tlv_one_type;
   logic [7:0]       req_tlv_two_type;
   logic             req_ring_path;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [1:0]       rsp_status;
   logic [4:0]       rsp_entry_index;
   logic [5:0]       rsp_node_count;
   logic [5:0]       rsp_removed_count;

   // Predicted table contents and register values
   entry_type        node_table [TABLE_ENTRIES];
   int               node_total;
   logic [CFG_W-1:0] cfg_lifetime;
   logic [CFG_W-1:0] cfg_step;
   report_type       pending_reports [$];

   int idle_odds;
   int errors;
   int settings_used;
   int beats_seen;
   int inserts_seen;
   int refreshes_seen;
   int fulls_seen;
   int ticks_seen;
   int expired_seen;

   ring_node_table_aging_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_node_mac      (req_node_mac),
      .req_sender_mac    (req_sender_mac),
      .req_seq_num       (req_seq_num),
      .req_tlv_zero_type (req_tlv_zero_type),
      .req_tlv_one_type  (req_tlv_one_type),
      .req_tlv_two_type  (req_tlv_two_type),
      .req_ring_path     (req_ring_path),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_node_count    (rsp_node_count),
      .rsp_removed_count (rsp_removed_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[MAC_W-1:0];
   endfunction

   function automatic frame_type update_frame(input logic [MAC_W-1:0] mac,
                                              input logic [MAC_W-1:0] redbox,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [7:0] t0, input logic [7:0] t1,
                                              input logic [7:0] t2, input path_type path);
      frame_type f;
      f.op         = OP_UPDATE;
      f.node_mac   = mac;
      f.sender_mac = redbox;
      f.seq_num    = seq;
      f.tlv_zero   = t0;
      f.tlv_one    = t1;
      f.tlv_two    = t2;
      f.path       = path;
      return f;
   endfunction

   function automatic frame_type random_frame(input op_type op, input logic [MAC_W-1:0] mac);
      frame_type f;
      f = update_frame(mac, rand_mac(), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), path_type'($urandom_range(0, 1)));
      f.op = op;
      return f;
   endfunction

   // Advances the predicted table by one beat and returns the expected report
   function automatic report_type apply_frame(input frame_type f);
      report_type rep;
      int      rd;
      int      slot;
      int      kept;
      int      gone;
      bit      hit;
      rep.status  = STATUS_TICK_DONE;
      rep.index   = '0;
      rep.removed = '0;
      if (f.op == OP_TICK) begin
         kept = 0;
         gone = 0;
         for (rd = 0; rd < node_total; rd++) begin
            if (node_table[rd].lifetime <= cfg_step) begin
               gone++;
            end else begin
               node_table[kept] = node_table[rd];
               node_table[kept].lifetime = node_table[kept].lifetime - cfg_step;
               kept++;
            end
         end
         node_total  = kept;
         rep.removed = 6'(gone);
      end else begin
         hit  = 1'b0;
         slot = 0;
         for (rd = 0; rd < node_total && !hit; rd++) begin
            if (node_table[rd].key == f.node_mac) begin
               hit  = 1'b1;
               slot = rd;
            end
         end
         if (hit) begin
            rep.status = STATUS_REFRESHED;
         end else if (node_total >= TABLE_ENTRIES) begin
            rep.status = STATUS_FULL;
         end else begin
            slot = node_total;
            node_total++;
            node_table[slot].seq_left  = '0;
            node_table[slot].seq_right = '0;
            rep.status = STATUS_INSERTED;
         end
         if (rep.status != STATUS_FULL) begin
            node_table[slot].key    = f.node_mac;
            node_table[slot].redbox = f.sender_mac;
            node_table[slot].tlv    = {f.tlv_zero, f.tlv_one, f.tlv_two};
            if (f.path == PATH_LEFT) begin
               node_table[slot].seq_left = f.seq_num;
            end else begin
               node_table[slot].seq_right = f.seq_num;
            end
            node_table[slot].lifetime = cfg_lifetime;
            rep.index = 5'(slot);
         end
      end
      rep.count = 6'(node_total);
      return rep;
   endfunction

   task automatic send_frame(input frame_type f);
      int gap;
      gap = ($urandom_range(0, 99) < idle_odds) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= f.op;
      req_node_mac      <= f.node_mac;
      req_sender_mac    <= f.sender_mac;
      req_seq_num       <= f.seq_num;
      req_tlv_zero_type <= f.tlv_zero;
      req_tlv_one_type  <= f.tlv_one;
      req_tlv_two_type  <= f.tlv_two;
      req_ring_path     <= f.path;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_reports.push_back(apply_frame(f));
   endtask

   task automatic drain_reports();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reports.size() != 0) begin
         $error("%0d expected results never arrived", pending_reports.size());
         errors++;
         pending_reports.delete();
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_W-1:0] new_lifetime,
                             input logic [CFG_W-1:0] new_step);
      drain_reports();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ENTRY_LIFETIME;
      csr_data  <= new_lifetime;
      @(posedge clock);
      cfg_lifetime = new_lifetime;
      csr_index <= CSR_AGE_STEP;
      csr_data  <= new_step;
      @(posedge clock);
      cfg_step = new_step;
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic test_reset_defaults();
      send_frame(random_frame(OP_TICK, '0));
      send_frame(update_frame('0, '1, 8'hff, 8'hff, 8'hff, 8'hff, PATH_LEFT));
      send_frame(update_frame('1, '0, 8'h00, 8'h00, 8'h00, 8'h00, PATH_RIGHT));
      send_frame(update_frame('0, 48'h0123_4567_89ab, 8'h5a, 8'h01, 8'h02, 8'h03,
                              PATH_RIGHT));
      send_frame(update_frame('1, 48'hfedc_ba98_7654, 8'ha5, 8'h80, 8'h40, 8'h20,
                              PATH_LEFT));
      send_frame(update_frame(48'h8000_0000_0001, 48'h5555_aaaa_5555, 8'h81, 8'h7f,
                              8'hfe, 8'h01, PATH_RIGHT));
      send_frame(random_frame(OP_TICK, '0));
      drain_reports();
   endtask

   task automatic test_expiry_rule();
      logic [MAC_W-1:0] mac_d;
      // lifetime equal to the step expires
      set_config(8'd255, 8'd255);
      send_frame(random_frame(OP_TICK, '0));
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      send_frame(random_frame(OP_TICK, '0));
      // adjacent removals mid-table, survivors close up in order
      set_config(8'd10, 8'd3);
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      set_config(8'd3, 8'd3);
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      set_config(8'd10, 8'd3);
      mac_d = rand_mac();
      send_frame(random_frame(OP_UPDATE, mac_d));
      send_frame(random_frame(OP_TICK, '0));
      send_frame(random_frame(OP_UPDATE, mac_d));
      send_frame(random_frame(OP_TICK, '0));
      set_config(8'd1, 8'd1);
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      send_frame(random_frame(OP_TICK, '0));
      drain_reports();
   endtask

   task automatic test_table_full();
      set_config(8'd200, 8'd1);
      while (node_total < TABLE_ENTRIES) begin
         send_frame(random_frame(OP_UPDATE, rand_mac()));
      end
      send_frame(random_frame(OP_UPDATE, rand_mac()));
      send_frame(random_frame(OP_UPDATE, node_table[TABLE_ENTRIES-1].key));
      send_frame(random_frame(OP_TICK, '0));
      set_config(8'd1, 8'd255);
      send_frame(random_frame(OP_TICK, '0));
      drain_reports();
   endtask

   task automatic test_random_traffic();
      logic [MAC_W-1:0] mac_pool [64];
      logic [MAC_W-1:0] base;
      logic [CFG_W-1:0] lifetime;
      logic [CFG_W-1:0] step;
      int               pool_size;
      int               phase_len;
      int               tick_pct;
      int               sent;
      int               k;
      int               pick;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 5))
            0: begin
               lifetime = 8'd255;
               step     = 8'd1;
            end
            1: begin
               lifetime = 8'($urandom_range(1, 255));
               step     = 8'd255;
            end
            2: begin
               lifetime = 8'd1;
               step     = 8'd1;
            end
            default: begin
               lifetime = 8'($urandom_range(1, 255));
               step     = 8'($urandom_range(1, lifetime / 4 + 1));
            end
         endcase
         set_config(lifetime, step);
         pool_size = $urandom_range(2, 48);
         base      = rand_mac();
         for (k = 0; k < pool_size; k++) begin
            // near neighbours stress the key compare
            mac_pool[k] = $urandom_range(0, 1) ? (base ^ (48'd1 << $urandom_range(0, 47)))
                                               : rand_mac();
         end
         phase_len = $urandom_range(80, 200);
         tick_pct  = $urandom_range(4, 20);
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 20;
            default: idle_odds = 50;
         endcase
         for (k = 0; k < phase_len && sent < RANDOM_BEATS; k++) begin
            if (sent >= RANDOM_BEATS - 200) idle_odds = 0;
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
               send_frame(random_frame(OP_TICK, rand_mac()));
            end else if (pick < tick_pct + 12) begin
               send_frame(random_frame(OP_UPDATE, rand_mac()));
            end else begin
               send_frame(random_frame(OP_UPDATE, mac_pool[$urandom_range(0, pool_size - 1)]));
            end
            sent++;
         end
      end
      drain_reports();
   endtask

   // Result side back-pressure in short bursts
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!rsp_stall && $urandom_range(0, 99) < idle_odds) begin
            hold = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : beat_checker
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want = pending_reports.pop_front();
            beats_seen++;
            if (rsp_status !== want.status) begin
               $error("rsp_status expected %0d actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_entry_index !== want.index) begin
               $error("rsp_entry_index expected %0d actual %0d", want.index, rsp_entry_index);
               errors++;
            end
            if (rsp_node_count !== want.count) begin
               $error("rsp_node_count expected %0d actual %0d", want.count, rsp_node_count);
               errors++;
            end
            if (rsp_removed_count !== want.removed) begin
               $error("rsp_removed_count expected %0d actual %0d", want.removed,
                      rsp_removed_count);
               errors++;
            end
            case (want.status)
               STATUS_REFRESHED: refreshes_seen++;
               STATUS_INSERTED:  inserts_seen++;
               STATUS_FULL:      fulls_seen++;
               default: begin
                  ticks_seen++;
                  expired_seen += want.removed;
               end
            endcase
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_ENTRY_LIFETIME;
      csr_data          <= '0;
      req_valid         <= 1'b0;
      req_op            <= OP_UPDATE;
      req_node_mac      <= '0;
      req_sender_mac    <= '0;
      req_seq_num       <= '0;
      req_tlv_zero_type <= '0;
      req_tlv_one_type  <= '0;
      req_tlv_two_type  <= '0;
      req_ring_path     <= PATH_LEFT;
      idle_odds         = 25;
      node_total        = 0;
      cfg_lifetime      = LIFETIME_RESET;
      cfg_step          = AGE_STEP_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_expiry_rule();
      test_table_full();
      test_random_traffic();
      drain_reports();
      repeat (40) @(posedge clock);
      $display("Covered %0d beats under %0d register settings: %0d inserted, %0d refreshed,",
               beats_seen, settings_used, inserts_seen, refreshes_seen);
      $display("%0d refused with the table full, %0d ticks expiring %0d entries in all.",
               fulls_seen, ticks_seen, expired_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $error("run timed out");
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/rnta_pkg.sv
src/rnta_ram.sv
src/rnta_ctrl.sv
src/rnta_dpath.sv
src/ring_node_table_aging_core.sv
dv/tb.sv
